/* rtl/core/sha1_pkg.sv */
package sha1_pkg;

	localparam logic [31:0] K_ROUND0 = 32'h5A82_7999;
	localparam logic [31:0] K_ROUND1 = 32'h6ED9_EBA1;
	localparam logic [31:0] K_ROUND2 = 32'h8F1B_BCDC;
	localparam logic [31:0] K_ROUND3 = 32'hCA62_C1D6;

	localparam logic [31:0] H_INIT0 = 32'h6745_2301;
	localparam logic [31:0] H_INIT1 = 32'hEFCD_AB89;
	localparam logic [31:0] H_INIT2 = 32'h98BA_DCFE;
	localparam logic [31:0] H_INIT3 = 32'h1032_5476;
	localparam logic [31:0] H_INIT4 = 32'hC3D2_E1F0;

	localparam logic [7:0] PAD_MARKER = 8'h80;

	localparam int unsigned NUM_WORDS  = 5;
	localparam int unsigned LAST_ROUND = 79;

	typedef logic [NUM_WORDS-1:0][31:0] hash_t;

	localparam hash_t H_INIT = {H_INIT4, H_INIT3, H_INIT2, H_INIT1, H_INIT0};

	// Round function, chosen by the round number.
	function automatic logic [31:0] sha1_f(input logic [6:0] t, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] res;
		if (t < 7'd20) begin
			res = (b & c) | (~b & d);
		end else if (t < 7'd40) begin
			res = b ^ c ^ d;
		end else if (t < 7'd60) begin
			res = (b & c) | (b & d) | (c & d);
		end else begin
			res = b ^ c ^ d;
		end
		return res;
	endfunction

	function automatic logic [31:0] sha1_k(input logic [6:0] t);
		logic [31:0] res;
		if (t < 7'd20) begin
			res = K_ROUND0;
		end else if (t < 7'd40) begin
			res = K_ROUND1;
		end else if (t < 7'd60) begin
			res = K_ROUND2;
		end else begin
			res = K_ROUND3;
		end
		return res;
	endfunction

endpackage

/* rtl/core/sha1_message_hash_top.sv */
// Streaming SHA-1 hash engine.
// Input channel (in_valid/in_ready): each beat carries msg_byte, byte_present and
// end_of_message. A beat with byte_present set appends msg_byte to the message; a
// beat with end_of_message set closes the message after any byte in the same beat.
// A beat with neither flag set is accepted and has no effect.
// Output channel (out_valid/out_ready): after a message closes, the digest leaves
// as five beats of digest_word, most significant word first, with word_index 0..4
// and last_word set on the fifth beat. The engine then starts the next message.
// Byte beats are taken back to back while the engine is idle. The 64th byte of a
// block starts the compression, one round per cycle through a single round adder:
// 80 rounds, then a fold of the result into the hash words. in_ready stays low
// through the rounds and the fold that follow that beat.
// After the end beat the padding is shifted in one byte per cycle and spills into
// a second block when the length does not fit; each padded block is compressed the
// same way, and then the first digest beat appears.
// The engine accepts no input while it compresses, pads or holds the digest. If
// the receiver stalls, the current digest word stays on the port unchanged.
// Reset loads the standard initial hash values and clears the byte count, so the
// first message needs no preparation.
module sha1_message_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha1_pkg::*;

	// IDLE takes bytes, MARK appends the 0x80 marker, ZERO appends zero fill and
	// length bytes, ROUND compresses, FINAL folds into the hash, OUT sends the digest.
	typedef enum logic [2:0] {
		S_IDLE,
		S_MARK,
		S_ZERO,
		S_ROUND,
		S_FINAL,
		S_OUT
	} state_t;

	state_t        state_q;
	state_t        ret_q;      // where to go once the running compression ends
	logic [511:0]  msg_q;      // block bytes, later the 16-word schedule window
	hash_t         h_q;
	logic [31:0]   a_q, b_q, c_q, d_q, e_q;
	logic [5:0]    fill_q;
	logic [60:0]   count_q;
	logic [6:0]    round_q;
	logic [2:0]    idx_q;
	logic          extra_q;    // length does not fit, a second padded block follows

	logic [63:0]   bit_len;
	logic [7:0]    len_byte;
	logic [7:0]    pad_byte;
	logic [31:0]   sched_x;
	logic [31:0]   w_t;
	logic [31:0]   round_sum;
	logic          in_fire;
	logic          out_fire;
	logic          block_full;
	state_t        after_in;

	// Word 0 of the window sits at the top of msg_q; taps are fixed positions.
	assign sched_x   = msg_q[95:64] ^ msg_q[255:224] ^ msg_q[447:416] ^ msg_q[511:480];
	assign w_t       = (round_q < 7'd16) ? msg_q[511:480] : {sched_x[30:0], sched_x[31]};
	assign round_sum = {a_q[26:0], a_q[31:27]} + sha1_f(round_q, b_q, c_q, d_q) + e_q
		+ sha1_k(round_q) + w_t;

	// The length bytes go out big-endian in the last eight positions of the block.
	assign bit_len  = {count_q, 3'b000};
	assign len_byte = bit_len[{~fill_q[2:0], 3'b000} +: 8];
	assign pad_byte = (fill_q[5:3] == 3'd7 && !extra_q) ? len_byte : 8'h00;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign in_fire     = in_valid && in_ready;
	assign out_fire    = out_valid && out_ready;
	assign block_full  = byte_present && (fill_q == 6'd63);
	assign after_in    = end_of_message ? S_MARK : S_IDLE;

	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'(NUM_WORDS - 1));

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire && byte_present) begin
					msg_q <= {msg_q[503:0], msg_byte};
				end
			end
			S_MARK: begin
				msg_q <= {msg_q[503:0], PAD_MARKER};
			end
			S_ZERO: begin
				msg_q <= {msg_q[503:0], pad_byte};
			end
			S_ROUND: begin
				msg_q <= {msg_q[479:0], w_t};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			h_q     <= H_INIT;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			e_q     <= '0;
			fill_q  <= '0;
			count_q <= '0;
			round_q <= '0;
			idx_q   <= '0;
			extra_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (byte_present) begin
							fill_q  <= fill_q + 6'd1;
							count_q <= count_q + 61'd1;
						end
						if (block_full) begin
							{e_q, d_q, c_q, b_q, a_q} <= h_q;
							round_q <= '0;
							ret_q   <= after_in;
							state_q <= S_ROUND;
						end else begin
							state_q <= after_in;
						end
					end
				end
				S_MARK: begin
					fill_q  <= fill_q + 6'd1;
					extra_q <= (fill_q[5:3] == 3'd7) && (fill_q[2:0] != 3'd7);
					if (fill_q == 6'd63) begin
						{e_q, d_q, c_q, b_q, a_q} <= h_q;
						round_q <= '0;
						ret_q   <= S_ZERO;
						state_q <= S_ROUND;
					end else begin
						state_q <= S_ZERO;
					end
				end
				S_ZERO: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						{e_q, d_q, c_q, b_q, a_q} <= h_q;
						round_q <= '0;
						ret_q   <= extra_q ? S_ZERO : S_OUT;
						extra_q <= 1'b0;
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					e_q <= d_q;
					d_q <= c_q;
					c_q <= {b_q[1:0], b_q[31:2]};
					b_q <= a_q;
					a_q <= round_sum;
					if (round_q == 7'(LAST_ROUND)) begin
						round_q <= '0;
						state_q <= S_FINAL;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				S_FINAL: begin
					h_q[0]  <= h_q[0] + a_q;
					h_q[1]  <= h_q[1] + b_q;
					h_q[2]  <= h_q[2] + c_q;
					h_q[3]  <= h_q[3] + d_q;
					h_q[4]  <= h_q[4] + e_q;
					state_q <= ret_q;
				end
				S_OUT: begin
					if (out_fire) begin
						if (idx_q == 3'(NUM_WORDS - 1)) begin
							idx_q   <= '0;
							h_q     <= H_INIT;
							count_q <= '0;
							fill_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The engine never takes input and offers a digest word in the same cycle.
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input and output offered together");

	// After the fifth digest beat the engine is ready for the next message.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> in_ready)
		else $error("engine not idle after last digest word");

	// An end-of-message beat always leads to padding, never straight to idle.
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && end_of_message) |=> !in_ready)
		else $error("end of message did not start padding");

	// The round counter ends a compression at the last round and folds the result.
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && round_q == 7'(LAST_ROUND)) |=> (state_q == S_FINAL))
		else $error("compression did not finish after the last round");

	// Digest beats carry positions 0 to 4 only.
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (word_index <= 3'(NUM_WORDS - 1)))
		else $error("digest word index out of range");

endmodule

/* bench/sha1_message_hash_top_tb.sv */
`timescale 1ns / 1ps

module sha1_message_hash_top_tb;

	// One input beat as the sender sees it.
	typedef struct {
		logic [7:0] data;
		logic       present;
		logic       eom;
	} msg_beat_t;

	// One digest beat as the receiver should see it.
	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	// The watchdog limit is many times the slowest quiet stretch of a correct run.
	// That stretch is a two-block padding pass with its two compressions, plus the
	// longest receiver stall and the longest sender gap.
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned RANDOM_ITEMS = 450;
	localparam int unsigned DRAIN_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  msg_byte = 8'h00;
	logic        byte_present = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha1_message_hash_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.msg_byte       (msg_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	// Beats waiting to be driven, and digest words waiting to come out.
	msg_beat_t    pending_beats[$];
	digest_beat_t digest_words_due[$];

	// Shadow copy of the hash engine state, advanced on every accepted beat.
	logic [31:0] hash_state [0:4];
	logic [7:0]  block_buf [0:63];
	logic [5:0]  fill_pos;
	logic [60:0] msg_len_bytes;

	int unsigned mismatches = 0;
	int unsigned items_queued = 0;
	int unsigned quiet_cycles = 0;

	// Set at each rising edge when the input beat on the port was taken, so that
	// the driver knows at the next falling edge whether to move on.
	logic in_took = 1'b0;

	// Sender burst and gap bookkeeping.
	int burst_left = 0;
	int gap_left = 0;

	// Receiver stall pattern bookkeeping.
	int rx_mode = 0;
	int rx_left = 0;

	digest_beat_t due_word;
	msg_beat_t    next_beat;
	msg_beat_t    seen_beat;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40) begin
			$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	task automatic reload_hash();
		hash_state[0] = sha1_pkg::H_INIT0;
		hash_state[1] = sha1_pkg::H_INIT1;
		hash_state[2] = sha1_pkg::H_INIT2;
		hash_state[3] = sha1_pkg::H_INIT3;
		hash_state[4] = sha1_pkg::H_INIT4;
	endtask

	// Runs the 80-round compression of block_buf into hash_state. The whole
	// schedule is expanded up front rather than kept in a 16-word ring.
	task automatic sha1_fold_block();
		logic [31:0] sched [0:79];
		logic [31:0] a, b, c, d, e, f, k, sum, mix;
		int r;
		for (r = 0; r < 16; r++) begin
			sched[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
		end
		for (r = 16; r < 80; r++) begin
			mix = sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16];
			sched[r] = {mix[30:0], mix[31]};
		end
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = sha1_pkg::K_ROUND0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = sha1_pkg::K_ROUND1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1_pkg::K_ROUND2;
			end else begin
				f = b ^ c ^ d;
				k = sha1_pkg::K_ROUND3;
			end
			sum = {a[26:0], a[31:27]} + f + e + k + sched[r];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = sum;
		end
		hash_state[0] = hash_state[0] + a;
		hash_state[1] = hash_state[1] + b;
		hash_state[2] = hash_state[2] + c;
		hash_state[3] = hash_state[3] + d;
		hash_state[4] = hash_state[4] + e;
	endtask

	// Advances the shadow state by one accepted beat. A closing beat pads the
	// message, folds the final block or blocks and queues the five digest words.
	task automatic predict_digest(input msg_beat_t bt);
		logic [63:0]  bit_len;
		digest_beat_t dw;
		int pos;
		int i;
		if (bt.present) begin
			block_buf[fill_pos] = bt.data;
			fill_pos = fill_pos + 6'd1;
			msg_len_bytes = msg_len_bytes + 61'd1;
			if (fill_pos == 6'd0) begin
				sha1_fold_block();
			end
		end
		if (bt.eom) begin
			pos = fill_pos;
			block_buf[pos] = sha1_pkg::PAD_MARKER;
			pos++;
			// No room left for the length: fill this block and start a new one.
			if (pos > 56) begin
				while (pos < 64) begin
					block_buf[pos] = 8'h00;
					pos++;
				end
				sha1_fold_block();
				pos = 0;
			end
			while (pos < 56) begin
				block_buf[pos] = 8'h00;
				pos++;
			end
			bit_len = {msg_len_bytes, 3'b000};
			for (i = 0; i < 8; i++) begin
				block_buf[63-i] = bit_len[8*i +: 8];
			end
			sha1_fold_block();
			for (i = 0; i < 5; i++) begin
				dw.word = hash_state[i];
				dw.index = i[2:0];
				dw.last = (i == 4);
				digest_words_due.push_back(dw);
			end
			reload_hash();
			fill_pos = 6'd0;
			msg_len_bytes = 61'd0;
		end
	endtask

	// Queues one beat. Beats that carry neither a byte nor an end do not count
	// toward the stimulus length, since the engine just drops them.
	task automatic queue_beat(input logic [7:0] data, input logic present, input logic eom);
		msg_beat_t bt;
		bt.data = data;
		bt.present = present;
		bt.eom = eom;
		pending_beats.push_back(bt);
		if (present || eom) begin
			items_queued++;
		end
	endtask

	// Queues a message of the given length with random content. Now and then a
	// dropped beat is mixed in, and the end either rides on the last byte or
	// follows as a beat of its own with a random, ignored byte value.
	task automatic queue_message(input int len);
		logic merge_end;
		int i;
		merge_end = (len > 0) && ($urandom_range(0, 1) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			queue_beat(8'($urandom_range(0, 255)), 1'b1, merge_end && (i == len - 1));
		end
		if (!merge_end) begin
			queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	// Stimulus: reset, a directed set of short messages, then random messages.
	initial begin
		int pick;
		int len;
		reload_hash();
		fill_pos = 6'd0;
		msg_len_bytes = 61'd0;

		// The empty message, closed by an end beat with no byte.
		queue_beat(8'h00, 1'b0, 1'b1);
		// "abc" with the end as a beat of its own.
		queue_beat(8'h61, 1'b1, 1'b0);
		queue_beat(8'h62, 1'b1, 1'b0);
		queue_beat(8'h63, 1'b1, 1'b0);
		queue_beat(8'hFF, 1'b0, 1'b1);
		// "abc" again with a dropped beat inside and the end on the last byte.
		queue_beat(8'h61, 1'b1, 1'b0);
		queue_beat(8'hA5, 1'b0, 1'b0);
		queue_beat(8'h62, 1'b1, 1'b0);
		queue_beat(8'h63, 1'b1, 1'b1);
		// Byte extremes: all zeros and all ones, end on the last byte.
		queue_beat(8'h00, 1'b1, 1'b0);
		queue_beat(8'hFF, 1'b1, 1'b1);
		// A single 0x80 byte, which looks like the pad marker itself.
		queue_beat(8'h80, 1'b1, 1'b1);
		// A dropped beat with every bit of the byte high, then an empty message.
		queue_beat(8'hFF, 1'b0, 1'b0);
		queue_beat(8'h5A, 1'b0, 1'b1);

		// Random messages. Most are short; some sit on the padding boundaries
		// where the length spills into a second block or a block fills exactly.
		while (items_queued < RANDOM_ITEMS + 14) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				len = $urandom_range(0, 20);
			end else if (pick < 7) begin
				case ($urandom_range(0, 6))
					0: len = 55;
					1: len = 56;
					2: len = 57;
					3: len = 63;
					4: len = 64;
					5: len = 65;
					default: len = 119 + $urandom_range(0, 9);
				endcase
			end else if (pick == 7) begin
				len = $urandom_range(0, 130);
			end else begin
				len = $urandom_range(1, 8);
			end
			queue_message(len);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the sender to run dry, then for the last digest to drain.
		while (pending_beats.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (digest_words_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (digest_words_due.size() != 0) begin
			flag_mismatch("digest words never delivered", digest_words_due.size(), 0);
		end
		if (mismatches == 0) begin
			$display("[sha1_message_hash_top] OK");
		end else begin
			$display("[sha1_message_hash_top] ERROR");
		end
		$finish;
	end

	// Sender: runs in bursts of random length separated by random gaps. A gap of
	// zero is common, so long stretches go by with no idling at all. Each beat is
	// held until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_beats.size() != 0) begin
				next_beat = pending_beats.pop_front();
				in_valid <= 1'b1;
				msg_byte <= next_beat.data;
				byte_present <= next_beat.present;
				end_of_message <= next_beat.eom;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					case ($urandom_range(0, 3))
						0, 1: gap_left = 0;
						2: gap_left = $urandom_range(1, 12);
						default: gap_left = $urandom_range(13, 30);
					endcase
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: switches between steady ready, a solid stall and a jittery
	// stretch where ready is drawn anew every cycle.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: rx_left = $urandom_range(20, 80);
				1: rx_left = $urandom_range(1, 15);
				default: rx_left = $urandom_range(10, 40);
			endcase
		end
		rx_left--;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'b0;
			default: out_ready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	// Monitor: feeds every accepted input beat to the predictor and checks every
	// accepted digest beat against the oldest word still due.
	always @(posedge clk) begin
		if (arst_n) begin
			in_took = in_valid && in_ready;
			if (in_took) begin
				seen_beat.data = msg_byte;
				seen_beat.present = byte_present;
				seen_beat.eom = end_of_message;
				predict_digest(seen_beat);
			end
			if (out_valid && out_ready) begin
				if (digest_words_due.size() == 0) begin
					flag_mismatch("digest beat with nothing due", digest_word, 0);
				end else begin
					due_word = digest_words_due.pop_front();
					if (digest_word !== due_word.word) begin
						flag_mismatch("digest_word", digest_word, due_word.word);
					end
					if (word_index !== due_word.index) begin
						flag_mismatch("word_index", 32'(word_index), 32'(due_word.index));
					end
					if (last_word !== due_word.last) begin
						flag_mismatch("last_word", 32'(last_word), 32'(due_word.last));
					end
				end
			end
		end
	end

	// Watchdog: a hung handshake on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
				$display("[sha1_message_hash_top] ERROR");
				$finish;
			end
		end
	end

endmodule

/* sha1_message_hash_top.f */
rtl/core/sha1_pkg.sv
rtl/core/sha1_message_hash_top.sv
bench/sha1_message_hash_top_tb.sv
